@@ hw/rtl/ray_segment_nearest_hit_defines.svh @@
// assertion macros shared by the ray segment hit block
`ifndef RAY_SEGMENT_NEAREST_HIT_DEFINES_SVH
`define RAY_SEGMENT_NEAREST_HIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RSNH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsnh assertion failed");

// next-cycle implication
`define RSNH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsnh assertion failed");

`else

`define RSNH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSNH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/rsnh_pkg.sv @@
`timescale 1ns / 1ps

package rsnh_pkg;

	// field widths
	localparam int COORD_W   = 32;
	localparam int DIR_W     = 16;
	localparam int CFG_IDX_W = 2;

	// datapath widths
	localparam int DIFF_W  = COORD_W + 1;           // coordinate differences
	localparam int MUL_W   = DIFF_W + 1;            // shared multiplier operand
	localparam int PROD_W  = 2 * MUL_W;             // shared multiplier product
	localparam int DEN_W   = DIFF_W + DIR_W + 1;    // den and n numerator
	localparam int MNUM_W  = 2 * DIFF_W + 1;        // m numerator, signed
	localparam int MABS_W  = MNUM_W - 1;            // m numerator magnitude
	localparam int MHALF_W = (MABS_W + 1) / 2;      // one half of the magnitude
	localparam int SCL_W   = MABS_W + DIR_W + 1;    // m numerator times |dir|
	localparam int QUOT_W  = 32;
	localparam int QCNT_W  = $clog2(QUOT_W);
	localparam int STEP_W  = 3;

	// multiply phase steps; the product of one step is taken up in the next
	localparam logic [STEP_W-1:0] MS_EX_DY = STEP_W'(0);
	localparam logic [STEP_W-1:0] MS_EY_DX = STEP_W'(1);
	localparam logic [STEP_W-1:0] MS_QX_DY = STEP_W'(2);
	localparam logic [STEP_W-1:0] MS_QY_DX = STEP_W'(3);
	localparam logic [STEP_W-1:0] MS_QX_EY = STEP_W'(4);
	localparam logic [STEP_W-1:0] MS_QY_EX = STEP_W'(5);
	localparam logic [STEP_W-1:0] MS_LAST  = STEP_W'(6);

	// scale phase steps
	localparam logic [STEP_W-1:0] SS_LO  = STEP_W'(0);
	localparam logic [STEP_W-1:0] SS_HI  = STEP_W'(1);
	localparam logic [STEP_W-1:0] SS_SUM = STEP_W'(2);
	localparam logic [STEP_W-1:0] SS_GO  = STEP_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_DIR_X,
		CFG_DIR_Y
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_SCALE,
		ST_DIV,
		ST_UPD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] seg_ax;
		logic signed [COORD_W-1:0] seg_ay;
		logic signed [COORD_W-1:0] seg_bx;
		logic signed [COORD_W-1:0] seg_by;
		logic                      last;
	} seg_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] hit_x;
		logic signed [COORD_W-1:0] hit_y;
	} res_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ hw/rtl/rsnh_mul.sv @@
`timescale 1ns / 1ps

module rsnh_mul (
	input  logic                                 clk,
	input  logic signed [rsnh_pkg::MUL_W-1:0]    a,
	input  logic signed [rsnh_pkg::MUL_W-1:0]    b,
	output logic signed [rsnh_pkg::PROD_W-1:0]   prod
);
	import rsnh_pkg::*;

	// signed product, registered
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

@@ hw/rtl/rsnh_div.sv @@
`timescale 1ns / 1ps

module rsnh_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsnh_pkg::div_ctrl_t               ctrl,
	input  logic [rsnh_pkg::SCL_W-1:0]        dividend,
	input  logic [rsnh_pkg::DEN_W-1:0]        divisor,
	output rsnh_pkg::div_stat_t               stat,
	output logic [rsnh_pkg::QUOT_W-1:0]       quot
);
	import rsnh_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    dsr_q;
	logic [QUOT_W-1:0]   num_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [DEN_W:0]      trial;
	logic [DEN_W+1:0]    diff;
	logic                fits;
	logic                sat;

	// quotient does not fit in QUOT_W bits: clamp to all ones
	assign sat   = dividend[SCL_W-1:QUOT_W] >= (SCL_W-QUOT_W)'(divisor);

	assign trial = {rem_q, num_q[QUOT_W-1]};
	assign diff  = {1'b0, trial} - (DEN_W+2)'(dsr_q);
	assign fits  = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dsr_q  <= divisor;
			rem_q  <= dividend[QUOT_W +: DEN_W];
			num_q  <= dividend[QUOT_W-1:0];
			quot_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q  <= {num_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

@@ hw/rtl/ray_segment_nearest_hit.sv @@
`timescale 1ns / 1ps
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//  seg      in         seg_valid / seg_stall    seg (rsnh_pkg::seg_t)
//  res      out        res_valid / res_stall    res (rsnh_pkg::res_t)
//
//  a miss runs six cross products on the shared multiplier over the seven multiply steps,
//  then one check state and one idle state
//  a hit adds two rounds of four scaling steps and a serial division, one round per axis;
//  a division whose quotient saturates ends without running its bit-serial loop
//  a segment with last set also passes through the emit state to load the result register
//  arst_n clears the sequencer, the held best hit and the ray to origin 0, direction (16384, 0)
//  res_stall only holds the final beat of a cast; a stalled result waits in its register

`include "ray_segment_nearest_hit_defines.svh"

module ray_segment_nearest_hit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rsnh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rsnh_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                 seg_valid,
	output logic                                 seg_stall,
	input  rsnh_pkg::seg_t                       seg,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output rsnh_pkg::res_t                       res
);
	import rsnh_pkg::*;

	// sequencer
	state_t                     state_q;
	state_t                     state_d;
	logic [STEP_W-1:0]          step_q;
	logic                       axis_q;     // 0: x component, 1: y component
	logic                       last_q;

	// ray configuration
	logic signed [COORD_W-1:0]  origin_x_q;
	logic signed [COORD_W-1:0]  origin_y_q;
	logic signed [DIR_W-1:0]    dir_x_q;
	logic signed [DIR_W-1:0]    dir_y_q;

	// segment terms, taken at accept
	logic signed [DIFF_W-1:0]   qx_q;
	logic signed [DIFF_W-1:0]   qy_q;
	logic signed [DIFF_W-1:0]   ex_q;
	logic signed [DIFF_W-1:0]   ey_q;

	// shared multiplier
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   prod;

	// cross products
	logic signed [DEN_W-1:0]    den_q;
	logic signed [DEN_W-1:0]    nnum_q;
	logic signed [MNUM_W-1:0]   mnum_q;
	logic signed [DEN_W-1:0]    den_c;
	logic signed [DEN_W-1:0]    nnum_c;
	logic signed [MNUM_W-1:0]   mnum_c;
	logic                       den_neg;
	logic                       hit_ok;

	// scaling and division
	logic [MABS_W-1:0]          mabs_q;
	logic [DEN_W-1:0]           dabs_q;
	logic [SCL_W-1:0]           scl_q;
	logic [DIR_W-1:0]           adx;
	logic [DIR_W-1:0]           ady;
	logic [DIR_W-1:0]           k_sel;
	div_ctrl_t                  div_ctrl;
	div_stat_t                  div_stat;
	logic [QUOT_W-1:0]          quot;
	logic [QUOT_W-1:0]          dxq_q;
	logic [QUOT_W-1:0]          dyq_q;

	// nearest hit tracking
	logic [QUOT_W-1:0]          param;
	logic                       take;
	logic                       found_q;
	logic [QUOT_W-1:0]          best_param_q;
	logic [COORD_W-1:0]         best_x_q;
	logic [COORD_W-1:0]         best_y_q;
	logic [COORD_W-1:0]         hx;
	logic [COORD_W-1:0]         hy;

	// result register
	logic                       res_valid_q;
	res_t                       res_q;
	logic                       res_free;
	logic                       seg_accept;

	// config writes must only be issued while idle; the block does not enforce it, and the port never holds off
	assign cfg_ready  = 1'b1;
	assign seg_stall  = (state_q != ST_IDLE);
	assign seg_accept = seg_valid && !seg_stall;
	assign res_free   = !res_valid_q || !res_stall;

	// |dir| per axis, -32768 folds to 32768 as unsigned
	assign adx   = dir_x_q[DIR_W-1] ? DIR_W'(-dir_x_q) : DIR_W'(dir_x_q);
	assign ady   = dir_y_q[DIR_W-1] ? DIR_W'(-dir_y_q) : DIR_W'(dir_y_q);
	assign k_sel = axis_q ? ady : adx;

	// normalize to a positive denominator; n must land in [0, den], m must be >= 0
	always_comb begin
		den_neg = den_q[DEN_W-1];
		den_c   = den_neg ? -den_q  : den_q;
		nnum_c  = den_neg ? -nnum_q : nnum_q;
		mnum_c  = den_neg ? -mnum_q : mnum_q;
		hit_ok  = (den_q != '0) && !mnum_c[MNUM_W-1] && !nnum_c[DEN_W-1] &&
			(nnum_c <= den_c);
	end

	// distance along the dominant axis of the direction orders hits by m
	always_comb begin
		param = (adx >= ady) ? dxq_q : dyq_q;
		take  = !found_q || (param < best_param_q);
		hx    = COORD_W'(origin_x_q) +
			(dir_x_q[DIR_W-1] ? -COORD_W'(dxq_q) : COORD_W'(dxq_q));
		hy    = COORD_W'(origin_y_q) +
			(dir_y_q[DIR_W-1] ? -COORD_W'(dyq_q) : COORD_W'(dyq_q));
	end

	rsnh_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	rsnh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (scl_q),
		.divisor  (dabs_q),
		.stat     (div_stat),
		.quot     (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_accept) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == MS_LAST) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (hit_ok) state_d = ST_SCALE;
				else if (last_q) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_SCALE: begin
				if (step_q == SS_GO) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) state_d = axis_q ? ST_UPD : ST_SCALE;
			end
			ST_UPD: begin
				state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and divider start
	always_comb begin
		mul_a          = '0;
		mul_b          = '0;
		div_ctrl       = '0;
		case (state_q)
			ST_MUL: begin
				case (step_q)
					MS_EX_DY: begin
						mul_a = MUL_W'(ex_q);
						mul_b = MUL_W'(dir_y_q);
					end
					MS_EY_DX: begin
						mul_a = MUL_W'(ey_q);
						mul_b = MUL_W'(dir_x_q);
					end
					MS_QX_DY: begin
						mul_a = MUL_W'(qx_q);
						mul_b = MUL_W'(dir_y_q);
					end
					MS_QY_DX: begin
						mul_a = MUL_W'(qy_q);
						mul_b = MUL_W'(dir_x_q);
					end
					MS_QX_EY: begin
						mul_a = MUL_W'(qx_q);
						mul_b = MUL_W'(ey_q);
					end
					MS_QY_EX: begin
						mul_a = MUL_W'(qy_q);
						mul_b = MUL_W'(ex_q);
					end
					default: ;
				endcase
			end
			ST_SCALE: begin
				case (step_q)
					// |mnum| * |dir| in two halves of the magnitude
					SS_LO: begin
						mul_a = MUL_W'(mabs_q[MHALF_W-1:0]);
						mul_b = MUL_W'(k_sel);
					end
					SS_HI: begin
						mul_a = MUL_W'(mabs_q[MABS_W-1:MHALF_W]);
						mul_b = MUL_W'(k_sel);
					end
					SS_GO: div_ctrl.start = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control state, ray registers and held best hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			axis_q       <= 1'b0;
			last_q       <= 1'b0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			dir_x_q      <= DIR_W'(16384);
			dir_y_q      <= '0;
			found_q      <= 1'b0;
			best_param_q <= '0;
			best_x_q     <= '0;
			best_y_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// step restarts on every state change
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;

			if (seg_accept) last_q <= seg.last;

			if (state_q == ST_CHK) axis_q <= 1'b0;
			else if (state_q == ST_DIV && div_stat.done) axis_q <= 1'b1;

			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ORIGIN_X: origin_x_q <= cfg_data;
					CFG_ORIGIN_Y: origin_y_q <= cfg_data;
					CFG_DIR_X:    dir_x_q    <= cfg_data[DIR_W-1:0];
					CFG_DIR_Y:    dir_y_q    <= cfg_data[DIR_W-1:0];
					default: ;
				endcase
			end

			// strict compare: on a tie the earlier segment stays
			if (state_q == ST_UPD && take) begin
				found_q      <= 1'b1;
				best_param_q <= param;
				best_x_q     <= hx;
				best_y_q     <= hy;
			end else if (state_q == ST_EMIT && res_free) begin
				found_q      <= 1'b0;
				best_param_q <= '0;
				best_x_q     <= '0;
				best_y_q     <= '0;
			end

			if (state_q == ST_EMIT && res_free) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (seg_accept) begin
			qx_q <= DIFF_W'(origin_x_q) - DIFF_W'(seg.seg_ax);
			qy_q <= DIFF_W'(origin_y_q) - DIFF_W'(seg.seg_ay);
			ex_q <= DIFF_W'(seg.seg_bx) - DIFF_W'(seg.seg_ax);
			ey_q <= DIFF_W'(seg.seg_by) - DIFF_W'(seg.seg_ay);
		end

		// each step takes up the product started one step earlier
		if (state_q == ST_MUL) begin
			case (step_q)
				MS_EY_DX: den_q  <= DEN_W'(prod);
				MS_QX_DY: den_q  <= den_q - DEN_W'(prod);
				MS_QY_DX: nnum_q <= DEN_W'(prod);
				MS_QX_EY: nnum_q <= nnum_q - DEN_W'(prod);
				MS_QY_EX: mnum_q <= MNUM_W'(prod);
				MS_LAST:  mnum_q <= mnum_q - MNUM_W'(prod);
				default: ;
			endcase
		end

		if (state_q == ST_CHK) begin
			mabs_q <= mnum_c[MABS_W-1:0];
			dabs_q <= DEN_W'(den_c);
		end

		if (state_q == ST_SCALE) begin
			case (step_q)
				SS_HI:  scl_q <= SCL_W'(unsigned'(prod));
				SS_SUM: scl_q <= scl_q + (SCL_W'(unsigned'(prod)) << MHALF_W);
				default: ;
			endcase
		end

		if (state_q == ST_DIV && div_stat.done) begin
			if (axis_q) dyq_q <= quot;
			else dxq_q <= quot;
		end

		if (state_q == ST_EMIT && res_free) begin
			res_q.hit   <= found_q;
			res_q.hit_x <= best_x_q;
			res_q.hit_y <= best_y_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// divider activity only ever belongs to the divide state
	`RSNH_ASSERT_IMP(a_div_owned, clk, arst_n, div_stat.busy || div_stat.done, state_q == ST_DIV)
	// an empty cast holds an all-zero best, so a miss reports zero coordinates
	`RSNH_ASSERT_IMP(a_empty_best, clk, arst_n, !found_q, best_x_q == '0 && best_y_q == '0 && best_param_q == '0)
	// emitting a cast clears the best and presents a beat
	`RSNH_ASSERT_NXT(a_emit_clears, clk, arst_n, state_q == ST_EMIT && res_free, !found_q && res_valid_q)
	// a hit is only scored against a nonzero denominator
	`RSNH_ASSERT_IMP(a_upd_den, clk, arst_n, state_q == ST_UPD, dabs_q != '0)

endmodule

@@ verif/ray_segment_nearest_hit_tb.sv @@
`timescale 1ns / 1ps

module ray_segment_nearest_hit_tb;
	import rsnh_pkg::*;

	localparam int     ONE        = 65536;          // 1.0 in Q16.16
	localparam int     C_MIN      = 32'sh8000_0000;
	localparam int     C_MAX      = 32'sh7FFF_FFFF;
	localparam int     DRAIN_WAIT = 100;            // covers the hit path plus the result load
	localparam int     PHASE_SEGS = 128;
	localparam int     N_PHASES   = 10;
	localparam int     HOLD_AFTER = 40;             // results seen before the long back-pressure
	localparam int     HOLD_LEN   = 1500;
	localparam longint LIMIT      = 1_000_000;

	typedef logic signed [127:0] wide_t;
	localparam wide_t QUOT_MAX = 128'hFFFF_FFFF;

	// directed segment, with a hand-computed cast result where one is easy to read off
	typedef struct packed {
		seg_t s;
		bit   typed;
		res_t want;
	} probe_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;
	logic                 seg_valid = 1'b0;
	logic                 seg_stall;
	seg_t                 seg       = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;

	ray_segment_nearest_hit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ray as the block should hold it, reset is origin 0 pointing along +x
	longint      ray_ox = 0;
	longint      ray_oy = 0;
	longint      ray_dx = 16384;
	longint      ray_dy = 0;

	// nearest hit of the cast in progress
	bit          cast_found = 1'b0;
	longint      cast_dist  = 0;
	logic [31:0] cast_x     = '0;
	logic [31:0] cast_y     = '0;

	res_t        nearest_q[$];      // cast results still owed by the block
	probe_t      probes[$];
	bit          calm = 1'b0;       // phase with no idling on either side

	int          results_seen = 0;
	int          n_bad        = 0;
	int          hold_left    = 0;
	int          stall_left   = 0;
	bit          held         = 1'b0;
	longint      cycles       = 0;

	// floor(num * k / d) clamped to 32 bits, num >= 0 and d > 0
	function automatic longint scaled_floor(wide_t num, longint k, longint d);
		wide_t q;
		q = (num * wide_t'(k)) / wide_t'(d);
		return (q > QUOT_MAX) ? 64'hFFFF_FFFF : longint'(q[63:0]);
	endfunction

	// fold one segment into the cast, returns 1 with the cast result on a last beat
	function automatic bit fold_segment(input seg_t s, output res_t r);
		longint qx, qy, ex, ey, den, nnum, adx, ady, reach, dxq, dyq, hx, hy;
		wide_t  mnum;
		qx   = ray_ox - longint'(s.seg_ax);
		qy   = ray_oy - longint'(s.seg_ay);
		ex   = longint'(s.seg_bx) - longint'(s.seg_ax);
		ey   = longint'(s.seg_by) - longint'(s.seg_ay);
		den  = ex * ray_dy - ey * ray_dx;
		nnum = qx * ray_dy - qy * ray_dx;
		mnum = wide_t'(qx) * wide_t'(ey) - wide_t'(qy) * wide_t'(ex);
		// normalize the sign so the hit test is m >= 0 and 0 <= n <= 1 on numerators
		if (den < 0) begin
			den  = -den;
			nnum = -nnum;
			mnum = -mnum;
		end
		// parallel and degenerate segments drop out on den == 0
		if (den != 0 && mnum >= 0 && nnum >= 0 && nnum <= den) begin
			adx   = (ray_dx < 0) ? -ray_dx : ray_dx;
			ady   = (ray_dy < 0) ? -ray_dy : ray_dy;
			reach = scaled_floor(mnum, (adx >= ady) ? adx : ady, den);
			// strict compare, the earlier segment keeps a tie
			if (!cast_found || reach < cast_dist) begin
				dxq        = scaled_floor(mnum, adx, den);
				dyq        = scaled_floor(mnum, ady, den);
				hx         = ray_ox + ((ray_dx < 0) ? -dxq : dxq);
				hy         = ray_oy + ((ray_dy < 0) ? -dyq : dyq);
				cast_found = 1'b1;
				cast_dist  = reach;
				cast_x     = hx[31:0];
				cast_y     = hy[31:0];
			end
		end
		r.hit   = cast_found;
		r.hit_x = cast_x;
		r.hit_y = cast_y;
		if (!s.last)
			return 1'b0;
		cast_found = 1'b0;
		cast_dist  = 0;
		cast_x     = '0;
		cast_y     = '0;
		return 1'b1;
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, logic [31:0] d);
		case (idx)
			CFG_ORIGIN_X: ray_ox = longint'(signed'(d));
			CFG_ORIGIN_Y: ray_oy = longint'(signed'(d));
			CFG_DIR_X:    ray_dx = longint'(signed'(d[15:0]));
			CFG_DIR_Y:    ray_dy = longint'(signed'(d[15:0]));
			default:      ;
		endcase
	endfunction

	// idle length, mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint sgn_rand(int bits);
		return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
	endfunction

	function automatic seg_t noise_seg();
		return {$urandom(), $urandom(), $urandom(), $urandom(), 1'b0};
	endfunction

	// segment through the ray point origin + t*dir; flat lays it along the ray
	function automatic seg_t aim_segment(longint t, bit flat);
		longint cx, cy, wx, wy, ka, kb;
		seg_t   s;
		cx = ray_ox + t * ray_dx;
		cy = ray_oy + t * ray_dy;
		wx = sgn_rand($urandom_range(2, 22));
		wy = sgn_rand($urandom_range(2, 22));
		if (flat) begin
			ka       = $urandom_range(1, 8);
			s.seg_ax = 32'(cx + wx);
			s.seg_ay = 32'(cy + wy);
			s.seg_bx = 32'(cx + wx + ka * ray_dx);
			s.seg_by = 32'(cy + wy + ka * ray_dy);
		end else begin
			// ka or kb of zero puts the ray point on an endpoint
			ka = $urandom_range(0, 3);
			kb = $urandom_range(0, 3);
			if (ka == 0 && kb == 0)
				kb = 1;
			s.seg_ax = 32'(cx + ka * wx);
			s.seg_ay = 32'(cy + ka * wy);
			s.seg_bx = 32'(cx - kb * wx);
			s.seg_by = 32'(cy - kb * wy);
		end
		s.last = 1'b0;
		return s;
	endfunction

	function automatic void probe(int ax, int ay, int bx, int by, bit last,
			bit typed = 1'b0, bit hit = 1'b0, int hx = 0, int hy = 0);
		probe_t p;
		p.s     = {ax, ay, bx, by, last};
		p.typed = typed;
		p.want  = {hit, hx, hy};
		probes.push_back(p);
	endfunction

	// offer one segment beat, valid stays up across back-to-back beats
	task automatic send_seg(input seg_t s, input bit typed, input res_t want);
		int   gap;
		res_t r;
		gap = idle_len();
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_valid <= 1'b1;
		seg       <= s;
		do @(posedge clk); while (seg_stall);
		if (fold_segment(s, r))
			nearest_q.push_back(typed ? want : r);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
	endtask

	// upper bits of the direction beats are junk the block must ignore
	task automatic write_ray(logic [31:0] ox, logic [31:0] oy, logic [15:0] dx, logic [15:0] dy);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_DIR_X, {16'($urandom()), dx});
		write_reg(CFG_DIR_Y, {16'($urandom()), dy});
		cfg_valid <= 1'b0;
	endtask

	// wait for owed results, then for a segment that may still be in flight
	task automatic settle();
		seg_valid <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// result side: check each accepted beat and drive the stall pattern
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (nearest_q.size() == 0) begin
					if (n_bad < 10)
						$display("result beat with nothing owed: hit=%0b x=%h y=%h",
							res.hit, res.hit_x, res.hit_y);
					n_bad++;
				end else begin
					want = nearest_q.pop_front();
					if (res.hit !== want.hit || res.hit_x !== want.hit_x ||
							res.hit_y !== want.hit_y) begin
						if (n_bad < 10)
							$display("cast result: expected hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
								want.hit, want.hit_x, want.hit_y, res.hit, res.hit_x, res.hit_y);
						n_bad++;
					end
				end
			end
			// one long hold so the result register fills and the block stalls its input
			if (!held && results_seen >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall  <= 1'b0;
				stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		res_t        none;
		seg_t        s;
		longint      t;
		int          kind, span, sent;
		logic [31:0] ox, oy;
		logic [15:0] dx, dy;
		none = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed casts under the reset ray, origin 0 along +x
		probe(5 * ONE, -ONE, 5 * ONE, ONE, 1'b1, 1'b1, 1'b1, 5 * ONE, 0);
		probe(0, ONE, 10 * ONE, ONE, 1'b1, 1'b1);                           // parallel
		probe(3 * ONE, 0, 3 * ONE, 0, 1'b1, 1'b1);                          // point segment
		probe(-5 * ONE, -ONE, -5 * ONE, ONE, 1'b1, 1'b1);                   // behind origin
		probe(7 * ONE, 0, 7 * ONE, 4 * ONE, 1'b1, 1'b1, 1'b1, 7 * ONE, 0);  // on start point
		probe(8 * ONE, -4 * ONE, 8 * ONE, 0, 1'b1, 1'b1, 1'b1, 8 * ONE, 0); // on end point
		probe(0, -ONE, 0, ONE, 1'b1, 1'b1, 1'b1, 0, 0);                     // through origin
		// nearest of three, the middle one
		probe(9 * ONE, -ONE, 9 * ONE, ONE, 1'b0);
		probe(4 * ONE, -ONE, 4 * ONE, ONE, 1'b0);
		probe(6 * ONE, -ONE, 6 * ONE, ONE, 1'b1, 1'b1, 1'b1, 4 * ONE, 0);
		// equal distance, first one held
		probe(3 * ONE, -ONE, 3 * ONE, ONE, 1'b0);
		probe(3 * ONE, -2 * ONE, 3 * ONE, 5 * ONE, 1'b1, 1'b1, 1'b1, 3 * ONE, 0);
		// coordinate extremes
		probe(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 1'b1, 1'b1, 0, 0);
		probe(C_MAX, C_MIN, C_MAX, C_MAX, 1'b1, 1'b1, 1'b1, C_MAX, 0);
		probe(C_MIN, C_MAX, C_MIN, C_MIN, 1'b1, 1'b1);
		// odd values, left to the predictor
		probe(2 * ONE + 123, 3 * ONE, -ONE, -7 * ONE - 5, 1'b1);
		probe(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);
		probe(-3 * ONE, -2 * ONE, 11 * ONE, 5 * ONE, 1'b0);
		probe(20 * ONE, ONE, 20 * ONE, -ONE, 1'b1);
		foreach (probes[i])
			send_seg(probes[i].s, probes[i].typed, probes[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			ox = $urandom();
			oy = $urandom();
			dx = 16'($urandom());
			dy = 16'($urandom());
			case (p)
				0: begin
					ox = '0;
					oy = '0;
					dx = 16'd16384;
					dy = 16'd16384;
				end
				1: begin
					ox = 32'h7FFF_FFFF;
					oy = 32'h8000_0000;
					dx = 16'h8000;
					dy = 16'h7FFF;
				end
				2: begin
					ox = 32'h8000_0000;
					oy = 32'h7FFF_FFFF;
					dx = 16'h7FFF;
					dy = 16'h8000;
				end
				3: begin
					// zero direction, nothing can hit
					dx = '0;
					dy = '0;
				end
				4: begin
					ox = 32'(sgn_rand(24));
					oy = 32'(sgn_rand(24));
					dx = '0;
					dy = 16'h8000;
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						ox = 32'(sgn_rand(24));
						oy = 32'(sgn_rand(24));
					end
				end
			endcase
			calm = (p == 0 || p == 5);
			write_ray(ox, oy, dx, dy);

			sent = 0;
			t    = 0;
			while (sent < PHASE_SEGS) begin
				if ($urandom_range(0, 4) != 0) begin
					// a cast of segments aimed at the ray
					span = $urandom_range(1, 8);
					for (int i = 0; i < span; i++) begin
						kind = $urandom_range(0, 9);
						// kind 8 keeps the last ray point for a tie
						if (kind != 8)
							t = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1 << 20))
								: longint'($urandom_range(0, 64));
						case (kind)
							6:       s = aim_segment(-t - 1, 1'b0);
							7:       s = aim_segment(t, 1'b1);
							9:       s = noise_seg();
							default: s = aim_segment(t, 1'b0);
						endcase
						s.last = (i == span - 1);
						send_seg(s, 1'b0, none);
					end
					sent += span;
				end else begin
					// loose noise, may leave a cast open across the next ray write
					s      = noise_seg();
					s.last = ($urandom_range(0, 3) == 0);
					send_seg(s, 1'b0, none);
					sent++;
				end
			end
		end

		settle();
		if (n_bad == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
